>>> hdl/cpra_pkg.sv
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared constants and types of the contiguous page run allocator.
// ----------------------------------------------------------------------------
package cpra_pkg;

  localparam int TOTAL_PAGES    = 256;
  localparam int RESERVED_PAGES = 8;

  localparam int PAGE_W = $clog2(TOTAL_PAGES);
  localparam int CNT_W  = PAGE_W + 1;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(TOTAL_PAGES - 1);
  // last page at which a run may still end: start + count < total - reserved
  localparam logic [PAGE_W-1:0] SCAN_LAST = PAGE_W'(TOTAL_PAGES - RESERVED_PAGES - 2);

  localparam logic [CNT_W-1:0] BOUNDARY_RESET = CNT_W'(TOTAL_PAGES);

  localparam logic MODE_RELEASE = 1'b0;
  localparam logic MODE_ALLOC   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] start_page;
  } out_item_t;

  // control from the sequencer to the row of page cells
  typedef struct packed {
    logic              shift;
    logic              set_en;
    logic [PAGE_W-1:0] set_page;
    logic              clr_en;
    logic [CNT_W-1:0]  clr_count;
  } row_ctrl_t;

endpackage

>>> hdl/cpra_cell.sv
// ----------------------------------------------------------------------------
// cpra_cell
// One page cell: holds a free mark and takes its neighbor's mark on a shift.
// ----------------------------------------------------------------------------
module cpra_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic nbr_i,
  input  logic set_i,
  input  logic clr_i,
  output logic free_o
);

  logic free_d, free_q;

  always_comb begin
    free_d = shift_i ? nbr_i : free_q;
    if (set_i) begin
      free_d = 1'b1;
    end
    if (clr_i) begin
      free_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b0;
    end else begin
      free_q <= free_d;
    end
  end

  assign free_o = free_q;

endmodule

>>> hdl/cpra_row.sv
// ----------------------------------------------------------------------------
// cpra_row
// Ring of page cells; rotates toward cell 0, which is the scan head.
// ----------------------------------------------------------------------------
module cpra_row (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpra_pkg::row_ctrl_t ctrl_i,
  output logic                head_o
);

  logic [cpra_pkg::TOTAL_PAGES-1:0] free_w;

  for (genvar i = 0; i < cpra_pkg::TOTAL_PAGES; i++) begin : g_cell
    logic set_w, clr_w;
    logic [cpra_pkg::CNT_W:0] reach_w;

    assign set_w = ctrl_i.set_en && (ctrl_i.set_page == cpra_pkg::PAGE_W'(i));
    // the last count cells hold the run that was just found
    assign reach_w = {1'b0, cpra_pkg::CNT_W'(i)} + {1'b0, ctrl_i.clr_count};
    assign clr_w   = ctrl_i.clr_en
                     && (reach_w >= (cpra_pkg::CNT_W + 1)'(cpra_pkg::TOTAL_PAGES));

    cpra_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.shift),
      .nbr_i   (free_w[(i + 1) % cpra_pkg::TOTAL_PAGES]),
      .set_i   (set_w),
      .clr_i   (clr_w),
      .free_o  (free_w[i])
    );
  end

  assign head_o = free_w[0];

endmodule

>>> hdl/contiguous_page_run_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// First-fit allocator of runs of consecutive free pages, with a ring of cells.
// ----------------------------------------------------------------------------
// release: no result; next item accepted the cycle after
// allocate: one full ring rotation over all pages, plus a clear of the run
//   found, plus loading the result, which waits while an earlier result is
//   held and not taken; next item accepted once the result is loaded
// one item at a time; the ring rotation over all pages sets the rate
// reset: every page used, memory boundary 256, no result pending
module contiguous_page_run_allocator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  cpra_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output cpra_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cpra_pkg::CNT_W-1:0]           cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_d, state_q;
  logic [cpra_pkg::PAGE_W-1:0] pos_d, pos_q;
  logic [cpra_pkg::CNT_W-1:0] run_d, run_q;
  logic [cpra_pkg::CNT_W-1:0] count_d, count_q;
  logic [cpra_pkg::CNT_W-1:0] bnd_d, bnd_q;
  logic found_d, found_q;
  logic [cpra_pkg::PAGE_W-1:0] start_d, start_q;
  logic out_valid_d, out_valid_q;
  cpra_pkg::out_item_t out_item_d, out_item_q;

  cpra_pkg::row_ctrl_t ctrl;
  logic head;
  logic in_acc;
  logic at_bnd;
  logic [cpra_pkg::CNT_W-1:0] run_next;
  logic hit;

  cpra_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // run of free pages ending at the head page, broken at the region boundary
  assign at_bnd = ({1'b0, pos_q} == bnd_q);
  always_comb begin
    if (!head) begin
      run_next = '0;
    end else if (at_bnd) begin
      run_next = cpra_pkg::CNT_W'(1);
    end else begin
      run_next = run_q + cpra_pkg::CNT_W'(1);
    end
  end

  assign hit = (state_q == ST_SCAN) && !found_q && head && (count_q != '0)
               && (run_next == count_q) && (pos_q <= cpra_pkg::SCAN_LAST);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    run_d       = run_q;
    count_d     = count_q;
    found_d     = found_q;
    start_d     = start_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    bnd_d       = bnd_q;

    ctrl           = '0;
    ctrl.set_page  = in_item_i.page;
    ctrl.clr_count = count_q;

    if (cfg_valid_i && cfg_ready_o) begin
      bnd_d = cfg_data_i;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.mode == cpra_pkg::MODE_RELEASE) begin
            ctrl.set_en = 1'b1;
          end else begin
            state_d = ST_SCAN;
            pos_d   = '0;
            run_d   = '0;
            count_d = in_item_i.count;
            found_d = 1'b0;
            start_d = '0;
          end
        end
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        pos_d      = pos_q + cpra_pkg::PAGE_W'(1);
        run_d      = run_next;
        if (hit) begin
          found_d = 1'b1;
          start_d = pos_q - count_q[cpra_pkg::PAGE_W-1:0] + cpra_pkg::PAGE_W'(1);
          state_d = ST_CLEAR;
        end else if (pos_q == cpra_pkg::LAST_PAGE) begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        // ring holds still while the run just passed is marked used
        ctrl.clr_en = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_item_d.found      = found_q;
          out_item_d.start_page = start_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      bnd_q       <= cpra_pkg::BOUNDARY_RESET;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      run_q       <= run_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      bnd_q       <= bnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    start_q    <= start_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_release_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.mode == cpra_pkg::MODE_RELEASE)) |=> !$rose(out_valid_o))
    else $error("release item produced a result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.found) |-> (out_item_o.start_page == '0))
    else $error("start page not zero on a failed allocation");

  a_clear_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (found_q && (count_q != '0)))
    else $error("run cleared without a hit");

  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (pos_q == '0))
    else $error("ring not aligned at end of scan");
`endif

endmodule

>>> dv/contiguous_page_run_allocator_tb.sv
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator_tb
// Drives release and allocate items through the allocator and checks each
// grant against a first-fit model of the page map kept in the bench. A short
// table of directed items comes first, then phases of random release bursts
// followed by allocations, each phase under the memory boundary written before it.
// ----------------------------------------------------------------------------
module contiguous_page_run_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 16;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 270;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 300;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    cpra_pkg::in_item_t  item;
    logic                typed;
    cpra_pkg::out_item_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  cpra_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cpra_pkg::out_item_t out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [cpra_pkg::CNT_W-1:0] cfg_data_i = '0;

  // bench copy of the page map and the boundary register
  logic [cpra_pkg::TOTAL_PAGES-1:0] page_free = '0;
  int                  region_split = cpra_pkg::TOTAL_PAGES;
  cpra_pkg::out_item_t pending_grants[$];
  int                  mismatches = 0;
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;

  // after reset nothing is free, so early allocations must fail
  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd1},   1'b1, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd0},   1'b1, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd255, 9'd511}, 1'b1, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd256}, 1'b1, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd0,   9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd0,   9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd255, 9'd511}, 1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd1},   1'b1, '{1'b1, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd1},   1'b1, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd247, 9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd1},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd246, 9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd1},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd10,  9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd11,  9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd12,  9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd3},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd248}, 1'b1, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd1,   9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd2,   9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd2},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd247}, 1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd128, 9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_RELEASE, 8'd127, 9'd0},   1'b0, '{1'b0, 8'd0}},
    '{'{cpra_pkg::MODE_ALLOC,   8'd0,   9'd2},   1'b0, '{1'b0, 8'd0}}
  };

  contiguous_page_run_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // lowest start below the reserved tail whose whole run is free and on one side
  function automatic cpra_pkg::out_item_t first_fit_alloc(input int n);
    cpra_pkg::out_item_t grant;
    int        lim;
    int        s;
    int        k;
    bit        fits;
    bit        upper;
    grant = '0;
    if (n == 0) return grant;
    lim = cpra_pkg::TOTAL_PAGES - cpra_pkg::RESERVED_PAGES - n;
    for (s = 0; s < lim; s++) begin
      fits  = 1'b1;
      upper = (s >= region_split);
      for (k = 0; k < n && fits; k++) begin
        if (s + k >= cpra_pkg::TOTAL_PAGES) fits = 1'b0;
        else if (!page_free[s+k] || ((s + k >= region_split) != upper)) fits = 1'b0;
      end
      if (fits) begin
        for (k = 0; k < n; k++) page_free[s+k] = 1'b0;
        grant.found      = 1'b1;
        grant.start_page = cpra_pkg::PAGE_W'(s);
        return grant;
      end
    end
    return grant;
  endfunction

  task automatic send_item(input cpra_pkg::in_item_t it, input logic typed,
                           input cpra_pkg::out_item_t want);
    cpra_pkg::out_item_t got;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      // mostly short gaps, now and then a longer one that can span a whole scan
      if ($urandom_range(7) == 0) repeat ($urandom_range(300, 9)) @(negedge clk_i);
      else repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.mode == cpra_pkg::MODE_ALLOC) begin
      got = first_fit_alloc(int'(it.count));
      pending_grants.push_back(typed ? want : got);
    end else begin
      page_free[it.page] = 1'b1;
    end
    @(negedge clk_i);
  endtask

  task automatic drain(input int settle);
    in_valid_i = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_boundary(input logic [cpra_pkg::CNT_W-1:0] value);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    region_split = int'(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // release a run of pages, then ask for about that many; plus noise items
  task automatic send_random_mix(input int n_items);
    cpra_pkg::in_item_t it;
    int       sent;
    int       pick;
    int       len;
    int       base;
    int       p;
    int       want_cnt;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      it   = '0;
      if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(8, 1);
        else if (pick < 92) len = $urandom_range(40, 9);
        else len = $urandom_range(247, 41);
        if (region_split > 0 && region_split < cpra_pkg::TOTAL_PAGES
            && $urandom_range(1) == 1) begin
          base = region_split - $urandom_range(len, 0);
          if (base < 0) base = 0;
        end else begin
          base = $urandom_range(cpra_pkg::TOTAL_PAGES - 1);
        end
        it.mode = cpra_pkg::MODE_RELEASE;
        for (p = base; p < base + len && p < cpra_pkg::TOTAL_PAGES; p++) begin
          it.page = cpra_pkg::PAGE_W'(p);
          it.count = cpra_pkg::CNT_W'($urandom);
          send_item(it, 1'b0, '0);
          sent++;
        end
        want_cnt = len + $urandom_range(2) - 1;
        it.mode  = cpra_pkg::MODE_ALLOC;
        it.page  = cpra_pkg::PAGE_W'($urandom);
        it.count = cpra_pkg::CNT_W'(want_cnt);
        send_item(it, 1'b0, '0);
        sent++;
      end else if (pick < 90) begin
        it.mode  = cpra_pkg::MODE_RELEASE;
        it.page  = cpra_pkg::PAGE_W'($urandom);
        it.count = cpra_pkg::CNT_W'($urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        it.mode  = cpra_pkg::MODE_ALLOC;
        it.page  = cpra_pkg::PAGE_W'($urandom);
        it.count = ($urandom_range(3) == 0) ? '0 : cpra_pkg::CNT_W'($urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cpra_pkg::out_item_t exp_grant;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        $display("%0t: grant with none pending: found %0d start %0d", $time,
                 out_item_o.found, out_item_o.start_page);
      end else begin
        exp_grant = pending_grants.pop_front();
        if (out_item_o.found !== exp_grant.found) begin
          mismatches++;
          $display("%0t: found expected %0d actual %0d", $time, exp_grant.found,
                   out_item_o.found);
        end
        if (out_item_o.start_page !== exp_grant.start_page) begin
          mismatches++;
          $display("%0t: start_page expected %0d actual %0d", $time,
                   exp_grant.start_page, out_item_o.start_page);
        end
      end
    end
  end

  initial begin
    logic [cpra_pkg::CNT_W-1:0] boundaries [PHASES];
    int i;
    boundaries[0] = '0;
    boundaries[1] = '1;
    boundaries[2] = cpra_pkg::CNT_W'(128);
    boundaries[3] = cpra_pkg::CNT_W'($urandom_range(255, 1));
    boundaries[4] = cpra_pkg::BOUNDARY_RESET;
    boundaries[5] = cpra_pkg::CNT_W'($urandom_range(511));
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
    end
    for (i = 0; i < PHASES; i++) begin
      drain(4);
      write_boundary(boundaries[i]);
      calm = (i == 2);
      // long receiver stall while items keep coming
      if (i == 3) hold_req = 1'b1;
      send_random_mix(PHASE_ITEMS);
    end
    drain(TAIL_CYCLES);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
